// ===== rtl/skvt_pkg.sv =====
// Shared constants, codes and types for the sorted key/value table.
package skvt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BYTES = 8;
  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int DATA_W = 64;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_REMOVE = 2'd3
  } skvt_cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } skvt_status_t;

  typedef struct packed {
    logic ins;
    logic rem;
    logic upd;
  } skvt_op_t;

endpackage

// ===== rtl/skvt_cell.sv =====
// One table cell: holds an entry, compares it with a probe key and shifts with its neighbors.
module skvt_cell (
  input  logic                      clk,
  input  logic                      sample,
  input  logic                      occ,
  input  logic [skvt_pkg::KEY_W-1:0]  probe_key,
  input  skvt_pkg::skvt_op_t        op,
  input  logic [skvt_pkg::KEY_W-1:0]  req_key,
  input  logic [skvt_pkg::DATA_W-1:0] req_value,
  input  logic [skvt_pkg::KEY_W-1:0]  left_key,
  input  logic [skvt_pkg::DATA_W-1:0] left_value,
  input  logic                      left_lt,
  input  logic [skvt_pkg::KEY_W-1:0]  right_key,
  input  logic [skvt_pkg::DATA_W-1:0] right_value,
  output logic [skvt_pkg::KEY_W-1:0]  key,
  output logic [skvt_pkg::DATA_W-1:0] value,
  output logic                      lt,
  output logic                      eq,
  output logic [skvt_pkg::DATA_W-1:0] hit_value
);

  logic match;

  assign match = occ && (key == probe_key);

  always_ff @(posedge clk) begin
    if (sample) begin
      lt <= occ && (key < probe_key);
      eq <= match;
      hit_value <= match ? value : '0;
    end
    priority if (op.ins && !lt) begin
      if (left_lt) begin
        key <= req_key;
        value <= req_value;
      end else begin
        key <= left_key;
        value <= left_value;
      end
    end else if (op.rem && !lt) begin
      key <= right_key;
      value <= right_value;
    end else if (op.upd && eq) begin
      value <= req_value;
    end
  end

endmodule

// ===== rtl/sorted_key_value_table.sv =====
// Top level of the sorted key/value table: request control and the chain of cells.
// A result is registered in the S_APPLY state after its request is accepted in S_IDLE.
// A new request is taken only in S_IDLE, once the previous one has been applied; every cell
// compares in the accept cycle and all cells shift or update together in the apply step.
// A waiting result does not block the next request; only its own apply step waits.
// Reset clears the entry count and the handshake state; cell contents are not cleared.
module sorted_key_value_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [1:0]                command,
  input  logic [63:0]               key,
  input  logic signed [63:0]        value,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic [1:0]                status,
  output logic [63:0]               found_key,
  output logic signed [63:0]        found_value,
  output logic [skvt_pkg::COUNT_OUT_W-1:0] entry_count
);

  localparam int N = skvt_pkg::TABLE_DEPTH;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t state;
  logic [skvt_pkg::CNT_W-1:0] count;
  skvt_pkg::skvt_cmd_t req_cmd;
  logic [skvt_pkg::KEY_W-1:0] req_key;
  logic [skvt_pkg::DATA_W-1:0] req_value;

  logic sample;
  logic apply_go;
  logic hit;
  logic full;
  skvt_pkg::skvt_op_t op;
  skvt_pkg::skvt_status_t status_next;
  logic [skvt_pkg::DATA_W-1:0] hit_or;

  logic [N-1:0] occ;
  logic [N-1:0] lt;
  logic [N-1:0] eq;
  logic [skvt_pkg::KEY_W-1:0] cell_key [N];
  logic [skvt_pkg::DATA_W-1:0] cell_value [N];
  logic [skvt_pkg::DATA_W-1:0] cell_hit [N];

  assign req_ready = (state == S_IDLE);
  assign sample = req_valid && req_ready;
  assign apply_go = (state == S_APPLY) && (!rsp_valid || rsp_ready);
  assign hit = |eq;
  assign full = (count == skvt_pkg::CNT_W'(N));

  always_comb begin
    op = '0;
    status_next = skvt_pkg::ST_OK;
    unique case (req_cmd)
      skvt_pkg::CMD_GET: begin
        if (!hit) status_next = skvt_pkg::ST_MISS;
      end
      skvt_pkg::CMD_ADD: begin
        if (hit) begin
          status_next = skvt_pkg::ST_MISS;
        end else if (full) begin
          status_next = skvt_pkg::ST_FULL;
        end else begin
          op.ins = apply_go;
        end
      end
      skvt_pkg::CMD_UPDATE: begin
        if (hit) op.upd = apply_go;
        else status_next = skvt_pkg::ST_MISS;
      end
      skvt_pkg::CMD_REMOVE: begin
        if (hit) op.rem = apply_go;
        else status_next = skvt_pkg::ST_MISS;
      end
      default: status_next = skvt_pkg::ST_MISS;
    endcase
  end

  always_comb begin
    hit_or = '0;
    for (int i = 0; i < N; i++) begin
      hit_or = hit_or | cell_hit[i];
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [skvt_pkg::KEY_W-1:0] lk;
    logic [skvt_pkg::DATA_W-1:0] lv;
    logic llt;
    logic [skvt_pkg::KEY_W-1:0] rk;
    logic [skvt_pkg::DATA_W-1:0] rv;

    assign occ[g] = (skvt_pkg::CNT_W'(g) < count);

    if (g == 0) begin : g_first
      assign lk = '0;
      assign lv = '0;
      assign llt = 1'b1;
    end else begin : g_mid
      assign lk = cell_key[g-1];
      assign lv = cell_value[g-1];
      assign llt = lt[g-1];
    end

    if (g == N - 1) begin : g_last
      assign rk = '0;
      assign rv = '0;
    end else begin : g_inner
      assign rk = cell_key[g+1];
      assign rv = cell_value[g+1];
    end

    skvt_cell u_cell (
      .clk         (clk),
      .sample      (sample),
      .occ         (occ[g]),
      .probe_key   (key[skvt_pkg::KEY_W-1:0]),
      .op          (op),
      .req_key     (req_key),
      .req_value   (req_value),
      .left_key    (lk),
      .left_value  (lv),
      .left_lt     (llt),
      .right_key   (rk),
      .right_value (rv),
      .key         (cell_key[g]),
      .value       (cell_value[g]),
      .lt          (lt[g]),
      .eq          (eq[g]),
      .hit_value   (cell_hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !apply_go) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (sample) begin
            req_cmd <= skvt_pkg::skvt_cmd_t'(command);
            req_key <= key[skvt_pkg::KEY_W-1:0];
            req_value <= value;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_go) begin
            if (op.ins) count <= count + 1'b1;
            else if (op.rem) count <= count - 1'b1;
            status <= status_next;
            if (req_cmd == skvt_pkg::CMD_GET && hit) begin
              found_key <= 64'(req_key);
              found_value <= hit_or;
            end else begin
              found_key <= '0;
              found_value <= '0;
            end
            entry_count <= skvt_pkg::COUNT_OUT_W'(
              op.ins ? count + 1'b1 : (op.rem ? count - 1'b1 : count));
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= skvt_pkg::CNT_W'(N))
    else $error("entry count above table depth");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> $onehot0(eq))
    else $error("more than one cell matches the key");

  a_sorted_prefix: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> (((lt & (lt + 1'b1)) == '0) && ((lt & eq) == '0)))
    else $error("below-key cells do not form a prefix");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    op.ins |=> (count == $past(count) + 1'b1))
    else $error("insert did not raise the entry count");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    op.rem |=> (count == $past(count) - 1'b1))
    else $error("remove did not lower the entry count");

endmodule

// ===== verif/sorted_key_value_table_checker.sv =====
// Checker for the sorted key/value table: tracks the table contents and compares every response.
module sorted_key_value_table_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_ready,
  input  logic [1:0]             command,
  input  logic [63:0]            key,
  input  logic signed [63:0]     value,
  input  logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  logic [1:0]             status,
  input  logic [63:0]            found_key,
  input  logic signed [63:0]     found_value,
  input  logic [skvt_pkg::COUNT_OUT_W-1:0] entry_count,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    skvt_pkg::skvt_cmd_t               cmd;
    logic [63:0]                       req_key;
    skvt_pkg::skvt_status_t            status;
    logic [63:0]                       fkey;
    logic signed [63:0]                fval;
    logic [skvt_pkg::COUNT_OUT_W-1:0]  count;
  } table_result_t;

  logic [skvt_pkg::KEY_W-1:0] stored_keys[skvt_pkg::TABLE_DEPTH];
  logic signed [63:0]         stored_values[skvt_pkg::TABLE_DEPTH];
  int                         occupancy;
  table_result_t              expected_q[$];

  initial begin
    mismatches = 0;
    outstanding = 0;
    occupancy = 0;
  end

  function automatic void predict_result(input skvt_pkg::skvt_cmd_t cmd,
                                         input logic [63:0] req_key,
                                         input logic signed [63:0] req_value,
                                         output table_result_t res);
    logic [skvt_pkg::KEY_W-1:0] k;
    int pos;
    bit hit;
    k = req_key[skvt_pkg::KEY_W-1:0];
    pos = 0;
    while (pos < occupancy && stored_keys[pos] < k) pos++;
    hit = (pos < occupancy) && (stored_keys[pos] == k);
    res.cmd = cmd;
    res.req_key = req_key;
    res.status = skvt_pkg::ST_OK;
    res.fkey = '0;
    res.fval = '0;
    case (cmd)
      skvt_pkg::CMD_GET: begin
        if (hit) begin
          res.fkey = 64'(stored_keys[pos]);
          res.fval = stored_values[pos];
        end else begin
          res.status = skvt_pkg::ST_MISS;
        end
      end
      skvt_pkg::CMD_ADD: begin
        if (hit) begin
          res.status = skvt_pkg::ST_MISS;
        end else if (occupancy >= skvt_pkg::TABLE_DEPTH) begin
          res.status = skvt_pkg::ST_FULL;
        end else begin
          for (int i = occupancy; i > pos; i--) begin
            stored_keys[i] = stored_keys[i-1];
            stored_values[i] = stored_values[i-1];
          end
          stored_keys[pos] = k;
          stored_values[pos] = req_value;
          occupancy++;
        end
      end
      skvt_pkg::CMD_UPDATE: begin
        if (hit) stored_values[pos] = req_value;
        else res.status = skvt_pkg::ST_MISS;
      end
      default: begin
        if (hit) begin
          for (int i = pos; i < occupancy - 1; i++) begin
            stored_keys[i] = stored_keys[i+1];
            stored_values[i] = stored_values[i+1];
          end
          occupancy--;
        end else begin
          res.status = skvt_pkg::ST_MISS;
        end
      end
    endcase
    res.count = skvt_pkg::COUNT_OUT_W'(occupancy);
  endfunction

  always @(posedge clk) begin
    table_result_t exp_res;
    table_result_t new_res;
    if (rst) begin
      occupancy = 0;
      expected_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected response status %0d key %h value %0d count %0d",
                     $realtime, status, found_key, found_value, entry_count);
        end else begin
          exp_res = expected_q.pop_front();
          if (status !== exp_res.status || found_key !== exp_res.fkey ||
              found_value !== exp_res.fval || entry_count !== exp_res.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch on %s key %h: expected status %0d key %h value %0d ",
                        "count %0d, got status %0d key %h value %0d count %0d"},
                       $realtime, exp_res.cmd.name(), exp_res.req_key, exp_res.status,
                       exp_res.fkey, exp_res.fval, exp_res.count, status, found_key,
                       found_value, entry_count);
          end
        end
      end
      if (req_valid && req_ready) begin
        predict_result(skvt_pkg::skvt_cmd_t'(command), key, value, new_res);
        expected_q.push_back(new_res);
      end
    end
    outstanding = expected_q.size();
  end

endmodule

// ===== verif/sorted_key_value_table_tb.sv =====
// Testbench top for the sorted key/value table: clock, reset, request stimulus and verdict.
module sorted_key_value_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1530;
  localparam int POOL_SIZE = 96;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      req_valid = 1'b0;
  logic                      req_ready;
  logic [1:0]                command = skvt_pkg::CMD_GET;
  logic [63:0]               key = '0;
  logic signed [63:0]        value = '0;
  logic                      rsp_valid;
  logic                      rsp_ready = 1'b0;
  logic [1:0]                status;
  logic [63:0]               found_key;
  logic signed [63:0]        found_value;
  logic [skvt_pkg::COUNT_OUT_W-1:0] entry_count;

  int                        mismatches;
  int                        outstanding;
  int                        cycle_count = 0;
  bit                        quiet = 1'b0;
  logic [63:0]               key_pool[POOL_SIZE];

  sorted_key_value_table dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .command(command), .key(key), .value(value),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .found_key(found_key), .found_value(found_value),
    .entry_count(entry_count)
  );

  sorted_key_value_table_checker checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .command(command), .key(key), .value(value),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .found_key(found_key), .found_value(found_value),
    .entry_count(entry_count),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ready <= quiet || ($urandom_range(99) >= 15);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [63:0] rand_value();
    case ($urandom_range(15))
      0: return 64'sh8000_0000_0000_0000;
      1: return 64'sh7FFF_FFFF_FFFF_FFFF;
      2: return 64'sd0;
      3: return -64'sd1;
      default: return rand64();
    endcase
  endfunction

  task automatic send_request(input skvt_pkg::skvt_cmd_t cmd, input logic [63:0] k,
                              input logic signed [63:0] v);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 15) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    command <= cmd;
    key <= k;
    value <= v;
    do @(posedge clk); while (!req_ready);
  endtask

  initial begin
    traffic_mode_t mode;
    skvt_pkg::skvt_cmd_t cmd;
    int pick;
    int zero_bytes;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      zero_bytes = $urandom_range(7);
      key_pool[i] = rand64() & ~((64'd1 << (8 * zero_bytes)) - 64'd1);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(skvt_pkg::CMD_GET, 64'd0, 64'sd5);
    send_request(skvt_pkg::CMD_UPDATE, '1, 64'sd7);
    send_request(skvt_pkg::CMD_REMOVE, 64'd0, -64'sd1);
    send_request(skvt_pkg::CMD_ADD, 64'd0, 64'sh8000_0000_0000_0000);
    send_request(skvt_pkg::CMD_ADD, '1, 64'sh7FFF_FFFF_FFFF_FFFF);
    send_request(skvt_pkg::CMD_ADD, 64'd0, 64'sd1);
    send_request(skvt_pkg::CMD_GET, 64'd0, 64'sd0);
    send_request(skvt_pkg::CMD_GET, '1, '1);
    send_request(skvt_pkg::CMD_UPDATE, '1, -64'sd1);
    send_request(skvt_pkg::CMD_GET, '1, 64'sd0);
    send_request(skvt_pkg::CMD_ADD, 64'h6162_6300_0000_0000, 64'sd0);
    send_request(skvt_pkg::CMD_ADD, 64'h6162_0000_0000_0000, 64'sd1);
    send_request(skvt_pkg::CMD_GET, 64'h6162_6300_0000_0000, 64'sh5555_5555_5555_5555);
    send_request(skvt_pkg::CMD_REMOVE, 64'd0, 64'sd0);
    send_request(skvt_pkg::CMD_GET, 64'd0, 64'sd0);
    send_request(skvt_pkg::CMD_REMOVE, '1, 64'sd0);
    send_request(skvt_pkg::CMD_UPDATE, 64'h6162_0000_0000_0000, 64'sh5555_5555_5555_5555);
    send_request(skvt_pkg::CMD_GET, 64'hAAAA_AAAA_AAAA_AAAA, 64'shAAAA_AAAA_AAAA_AAAA);
    send_request(skvt_pkg::CMD_REMOVE, 64'h6162_0000_0000_0000, 64'sd0);
    send_request(skvt_pkg::CMD_REMOVE, 64'h6162_6300_0000_0000, 64'sd0);

    // Segments of requests cycle through fill-heavy, mixed, drain-heavy and mixed traffic.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 700 && n < 1000);
      case ((n / 100) % 6)
        0, 1: mode = MODE_FILL;
        3, 4: mode = MODE_DRAIN;
        default: mode = MODE_MIXED;
      endcase
      pick = $urandom_range(99);
      case (mode)
        MODE_FILL:
          cmd = (pick < 70) ? skvt_pkg::CMD_ADD : (pick < 80) ? skvt_pkg::CMD_GET :
                (pick < 90) ? skvt_pkg::CMD_UPDATE : skvt_pkg::CMD_REMOVE;
        MODE_DRAIN:
          cmd = (pick < 55) ? skvt_pkg::CMD_REMOVE : (pick < 75) ? skvt_pkg::CMD_GET :
                (pick < 90) ? skvt_pkg::CMD_UPDATE : skvt_pkg::CMD_ADD;
        default:
          cmd = skvt_pkg::skvt_cmd_t'(pick % 4);
      endcase
      if ($urandom_range(9) == 0)
        send_request(cmd, rand64(), rand_value());
      else
        send_request(cmd, key_pool[$urandom_range(POOL_SIZE - 1)], rand_value());
    end
    quiet = 1'b0;

    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
